FILE: sv/bspu_pkg.sv
// bspu_pkg: shared types, codes and the sigmoid table for the binary swarm update
// used by binary_swarm_particle_update and its testbench; depends on nothing
`default_nettype none

package bspu_pkg;

    // field widths fixed by the item format
    localparam int IDX_W  = 6;
    localparam int VEL_W  = 16;
    localparam int RND_W  = 16;
    localparam int GAIN_W = 12;

    // default particle length
    localparam int VECTOR_LENGTH_DEF = 64;

    // command codes
    localparam logic [1:0] CMD_INIT   = 2'd0;
    localparam logic [1:0] CMD_UPDATE = 2'd1;
    localparam logic [1:0] CMD_SAVE   = 2'd2;

    // configuration register indexes
    localparam logic CFG_ALPHA = 1'b0;
    localparam logic CFG_BETA  = 1'b1;

    // gain reset values, 1.0 in Q4.8
    localparam logic [GAIN_W-1:0] GAIN_RESET = 12'd256;

    typedef struct packed {
        logic [1:0]       command;
        logic [IDX_W-1:0] element_index;
        logic             global_best_bit;
        logic [RND_W-1:0] random_value;
    } in_item_t;

    typedef struct packed {
        logic [IDX_W-1:0]        out_index;
        logic                    current_bit;
        logic                    local_best_bit;
        logic signed [VEL_W-1:0] velocity;
    } out_item_t;

    // per-element stored state
    typedef struct packed {
        logic                    pos;
        logic                    best;
        logic signed [VEL_W-1:0] vel;
    } elem_state_t;

    // logistic curve over [-8, 8) in steps of 0.25, scaled to 65536
    function automatic logic [RND_W-1:0] sigmoid_lut(input logic [5:0] k);
        logic [RND_W-1:0] r;
        case (k)
            6'd0:  r = 16'd22;    6'd1:  r = 16'd28;    6'd2:  r = 16'd36;
            6'd3:  r = 16'd47;    6'd4:  r = 16'd60;    6'd5:  r = 16'd77;
            6'd6:  r = 16'd98;    6'd7:  r = 16'd126;   6'd8:  r = 16'd162;
            6'd9:  r = 16'd208;   6'd10: r = 16'd267;   6'd11: r = 16'd342;
            6'd12: r = 16'd439;   6'd13: r = 16'd562;   6'd14: r = 16'd720;
            6'd15: r = 16'd922;   6'd16: r = 16'd1179;  6'd17: r = 16'd1506;
            6'd18: r = 16'd1921;  6'd19: r = 16'd2446;  6'd20: r = 16'd3108;
            6'd21: r = 16'd3938;  6'd22: r = 16'd4971;  6'd23: r = 16'd6249;
            6'd24: r = 16'd7812;  6'd25: r = 16'd9702;  6'd26: r = 16'd11955;
            6'd27: r = 16'd14595; 6'd28: r = 16'd17625; 6'd29: r = 16'd21025;
            6'd30: r = 16'd24743; 6'd31: r = 16'd28693; 6'd32: r = 16'd32768;
            6'd33: r = 16'd36843; 6'd34: r = 16'd40793; 6'd35: r = 16'd44511;
            6'd36: r = 16'd47911; 6'd37: r = 16'd50941; 6'd38: r = 16'd53581;
            6'd39: r = 16'd55834; 6'd40: r = 16'd57724; 6'd41: r = 16'd59287;
            6'd42: r = 16'd60565; 6'd43: r = 16'd61598; 6'd44: r = 16'd62428;
            6'd45: r = 16'd63090; 6'd46: r = 16'd63615; 6'd47: r = 16'd64030;
            6'd48: r = 16'd64357; 6'd49: r = 16'd64614; 6'd50: r = 16'd64816;
            6'd51: r = 16'd64974; 6'd52: r = 16'd65097; 6'd53: r = 16'd65194;
            6'd54: r = 16'd65269; 6'd55: r = 16'd65328; 6'd56: r = 16'd65374;
            6'd57: r = 16'd65410; 6'd58: r = 16'd65438; 6'd59: r = 16'd65459;
            6'd60: r = 16'd65476; 6'd61: r = 16'd65489; 6'd62: r = 16'd65500;
            6'd63: r = 16'd65508;
            default: r = 16'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: sv/binary_swarm_particle_update.sv
// Binary swarm particle update: per-element initialize, velocity update and save-best.
// An accepted item passes through the compute stage, then the result register;
// throughput 1 item per cycle, set by one read-modify-write of the element RAM
// per cycle with a same-element bypass; input stalls while a result waits on m_ready
// or the clearing pass runs. Reset: synchronous active-low; gains return to 1.0, then a
// clearing pass zeroes each word of the element RAM, during which s_ready stays low.
`default_nettype none

module binary_swarm_particle_update #(
    parameter int VECTOR_LENGTH = bspu_pkg::VECTOR_LENGTH_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // input items
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire bspu_pkg::in_item_t            s_data,
    // result items
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output bspu_pkg::out_item_t                m_data,
    // configuration writes
    input  wire logic                          cfg_wr_en,
    input  wire logic                          cfg_index,
    input  wire logic [bspu_pkg::GAIN_W-1:0]   cfg_wr_data
);

    import bspu_pkg::*;

    localparam int AW = (VECTOR_LENGTH > 1) ? $clog2(VECTOR_LENGTH) : 1;
    localparam int SW = $bits(elem_state_t);

    // configuration
    logic [GAIN_W-1:0] alpha_reg, beta_reg;

    // clearing pass
    logic          clr_active_reg;
    logic [AW-1:0] clr_addr_reg;

    // compute stage
    logic          s1_valid_reg;
    in_item_t      s1_item_reg;
    logic          fwd_hit_reg;
    elem_state_t   fwd_data_reg;

    // result register
    logic          m_valid_reg;
    out_item_t     m_data_reg;

    logic          accept, s1_adv;
    logic [AW-1:0] rd_addr, s1_addr;
    logic [IDX_W+AW-1:0] rd_ext, s1_ext;
    logic          s1_in_range;
    logic [SW-1:0] ram_rdata;
    elem_state_t   old_st, new_st;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [SW-1:0] ram_wdata;
    out_item_t     res_next;

    // handshake
    assign s1_adv  = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !clr_active_reg && (!s1_valid_reg || !m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;

    // element addresses
    assign rd_ext  = {{AW{1'b0}}, s_data.element_index};
    assign rd_addr = rd_ext[AW-1:0];
    assign s1_ext  = {{AW{1'b0}}, s1_item_reg.element_index};
    assign s1_addr = s1_ext[AW-1:0];
    assign s1_in_range = 32'(s1_item_reg.element_index) < VECTOR_LENGTH;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg <= GAIN_RESET;
            beta_reg  <= GAIN_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_ALPHA: alpha_reg <= cfg_wr_data;
                CFG_BETA:  beta_reg  <= cfg_wr_data;
                default:   alpha_reg <= alpha_reg;
            endcase
        end
    end

    // clearing pass after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end else if (clr_active_reg) begin
            clr_addr_reg <= clr_addr_reg + AW'(1);
            if (clr_addr_reg == AW'(VECTOR_LENGTH - 1)) begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    // element state memory
    assign ram_we    = clr_active_reg || (s1_adv && s1_in_range);
    assign ram_waddr = clr_active_reg ? clr_addr_reg : s1_addr;
    assign ram_wdata = clr_active_reg ? '0 : new_st;

    bspu_ram #(
        .WIDTH (SW),
        .DEPTH (VECTOR_LENGTH),
        .AW    (AW)
    ) u_state_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // compute stage register and same-element bypass
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end else begin
            if (accept) begin
                s1_valid_reg <= 1'b1;
                fwd_hit_reg  <= s1_adv && s1_in_range && (s1_addr == rd_addr);
            end else if (s1_adv) begin
                s1_valid_reg <= 1'b0;
                fwd_hit_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_item_reg  <= s_data;
            fwd_data_reg <= new_st;
        end
    end

    // element update
    always_comb begin
        logic signed [12:0] a_term, b_term;
        logic signed [17:0] vsum;
        logic signed [VEL_W-1:0] vsat;
        logic [11:0] vclamp;
        logic [RND_W-1:0] thresh;

        old_st = fwd_hit_reg ? fwd_data_reg : elem_state_t'(ram_rdata);
        new_st = old_st;

        // gain terms, each difference is -1, 0 or +1
        if (old_st.best && !old_st.pos) begin
            a_term = $signed({1'b0, alpha_reg});
        end else if (!old_st.best && old_st.pos) begin
            a_term = -$signed({1'b0, alpha_reg});
        end else begin
            a_term = '0;
        end
        if (s1_item_reg.global_best_bit && !old_st.pos) begin
            b_term = $signed({1'b0, beta_reg});
        end else if (!s1_item_reg.global_best_bit && old_st.pos) begin
            b_term = -$signed({1'b0, beta_reg});
        end else begin
            b_term = '0;
        end

        // saturating velocity sum
        vsum = $signed({{2{old_st.vel[VEL_W-1]}}, old_st.vel})
             + $signed({{5{a_term[12]}}, a_term})
             + $signed({{5{b_term[12]}}, b_term});
        if (vsum > 18'sd32767) begin
            vsat = 16'sh7FFF;
        end else if (vsum < -18'sd32768) begin
            vsat = 16'sh8000;
        end else begin
            vsat = vsum[VEL_W-1:0];
        end

        // clamp to [-8, 8) and look up the sigmoid
        if (vsat > 16'sd2047) begin
            vclamp = 12'h7FF;
        end else if (vsat < -16'sd2048) begin
            vclamp = 12'h800;
        end else begin
            vclamp = vsat[11:0];
        end
        thresh = sigmoid_lut({~vclamp[11], vclamp[10:6]});

        case (s1_item_reg.command)
            CMD_INIT: begin
                new_st.pos = s1_item_reg.random_value[0];
            end
            CMD_UPDATE: begin
                new_st.vel = vsat;
                new_st.pos = s1_item_reg.random_value < thresh;
            end
            CMD_SAVE: begin
                new_st.best = old_st.pos;
            end
            default: begin
                new_st = old_st;
            end
        endcase

        // result
        res_next.out_index = s1_item_reg.element_index;
        if (s1_in_range) begin
            res_next.current_bit    = new_st.pos;
            res_next.local_best_bit = new_st.best;
            res_next.velocity       = new_st.vel;
        end else begin
            res_next.current_bit    = 1'b0;
            res_next.local_best_bit = 1'b0;
            res_next.velocity       = '0;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            m_data_reg <= res_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef NO_ASSERTIONS
    // no item is in flight while the memory is being cleared
    a_clear_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_active_reg |-> !s1_valid_reg && !m_valid_reg)
        else $error("item in flight during clearing pass");

    // an accepted item always lands in the compute stage
    a_accept_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> s1_valid_reg)
        else $error("accepted item lost");

    // bypass only applies to an item held in the compute stage
    a_fwd_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        fwd_hit_reg |-> s1_valid_reg)
        else $error("bypass flag without item");

    // out-of-range elements report zero state
    a_out_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (32'(m_data_reg.out_index) >= VECTOR_LENGTH)) |->
        (!m_data_reg.current_bit && !m_data_reg.local_best_bit &&
         (m_data_reg.velocity == '0)))
        else $error("out-of-range result not zero");

    // a stalled result holds while a new item waits in the compute stage
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready && s1_valid_reg) |=> s1_valid_reg && m_valid_reg)
        else $error("item dropped under back-pressure");
`endif

endmodule

`default_nettype wire

FILE: sv/bspu_ram.sv
// bspu_ram: generic single-port-write, single-port-read RAM with registered read
// read returns the old word on a same-address write; uses no package
`default_nettype none

module bspu_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: tb/binary_swarm_particle_update_test.sv
// binary_swarm_particle_update_test: self-checking bench for the binary swarm element update
// directed table then random gain phases, random stalls on both channels, local predictor
// depends on bspu_pkg and binary_swarm_particle_update
module binary_swarm_particle_update_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bspu_pkg::*;

    localparam int ELEMENTS = VECTOR_LENGTH_DEF;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [GAIN_W-1:0] GAIN_MAX = 12'd4095;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS = 191;
    localparam int MAX_SHOWN = 40;

    // one row of the directed table: a gain write or an item
    typedef struct {
        bit                cfg_write;
        logic              cfg_sel;
        logic [GAIN_W-1:0] cfg_value;
        in_item_t          item;
        bit                typed_in;
        out_item_t         typed_result;
    } stim_row_t;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    in_item_t          s_data;
    logic              m_valid;
    logic              m_ready;
    out_item_t         m_data;
    logic              cfg_wr_en;
    logic              cfg_index;
    logic [GAIN_W-1:0] cfg_wr_data;

    // predicted particle state and gains
    logic                    pos_bits [ELEMENTS];
    logic                    best_bits [ELEMENTS];
    logic signed [VEL_W-1:0] velocities [ELEMENTS];
    logic [GAIN_W-1:0]       alpha_gain_q;
    logic [GAIN_W-1:0]       beta_gain_q;

    // logistic curve over [-8, 8) in quarter steps, scaled to 65536
    logic [RND_W-1:0] logistic_steps [64] = '{
        16'd22,    16'd28,    16'd36,    16'd47,    16'd60,    16'd77,    16'd98,    16'd126,
        16'd162,   16'd208,   16'd267,   16'd342,   16'd439,   16'd562,   16'd720,   16'd922,
        16'd1179,  16'd1506,  16'd1921,  16'd2446,  16'd3108,  16'd3938,  16'd4971,  16'd6249,
        16'd7812,  16'd9702,  16'd11955, 16'd14595, 16'd17625, 16'd21025, 16'd24743, 16'd28693,
        16'd32768, 16'd36843, 16'd40793, 16'd44511, 16'd47911, 16'd50941, 16'd53581, 16'd55834,
        16'd57724, 16'd59287, 16'd60565, 16'd61598, 16'd62428, 16'd63090, 16'd63615, 16'd64030,
        16'd64357, 16'd64614, 16'd64816, 16'd64974, 16'd65097, 16'd65194, 16'd65269, 16'd65328,
        16'd65374, 16'd65410, 16'd65438, 16'd65459, 16'd65476, 16'd65489, 16'd65500, 16'd65508
    };

    out_item_t pending_results [$];
    stim_row_t directed_rows [$];
    bit        idle_bursts;
    int        errors;
    int        items_sent;
    int        results_checked;
    int        directed_items;

    binary_swarm_particle_update i_dut (
        .aclk,
        .aresetn,
        .s_valid,
        .s_ready,
        .s_data,
        .m_valid,
        .m_ready,
        .m_data,
        .cfg_wr_en,
        .cfg_index,
        .cfg_wr_data
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // apply one item to the predicted state, return the element after the step
    function automatic out_item_t predict_element(input in_item_t it);
        out_item_t r;
        int idx;
        int v;
        int clamped;
        int dl;
        int dg;
        // a 6-bit index always lands inside the 64-element particle
        idx = int'(it.element_index);
        case (it.command)
            CMD_INIT: pos_bits[idx] = it.random_value[0];
            CMD_UPDATE: begin
                dl = int'(best_bits[idx]) - int'(pos_bits[idx]);
                dg = int'(it.global_best_bit) - int'(pos_bits[idx]);
                v = int'(velocities[idx]) + int'(alpha_gain_q) * dl + int'(beta_gain_q) * dg;
                if (v > 32767) v = 32767;
                if (v < -32768) v = -32768;
                velocities[idx] = VEL_W'(v);
                // sigmoid lookup on the velocity clamped to [-8, 8)
                clamped = v;
                if (clamped > 2047) clamped = 2047;
                if (clamped < -2048) clamped = -2048;
                pos_bits[idx] = int'(it.random_value) <
                    int'(logistic_steps[(clamped + 2048) >> 6]);
            end
            CMD_SAVE: best_bits[idx] = pos_bits[idx];
            default: ;
        endcase
        r.out_index      = it.element_index;
        r.current_bit    = pos_bits[idx];
        r.local_best_bit = best_bits[idx];
        r.velocity       = velocities[idx];
        return r;
    endfunction

    function automatic stim_row_t item_row(input logic [1:0] cmd, input int idx, input logic g,
                                           input logic [RND_W-1:0] rnd, input bit typed_in,
                                           input logic cur, input logic best, input int vel);
        stim_row_t row;
        row.cfg_write                 = 1'b0;
        row.cfg_sel                   = CFG_ALPHA;
        row.cfg_value                 = '0;
        row.item.command              = cmd;
        row.item.element_index        = IDX_W'(idx);
        row.item.global_best_bit      = g;
        row.item.random_value         = rnd;
        row.typed_in                  = typed_in;
        row.typed_result.out_index    = IDX_W'(idx);
        row.typed_result.current_bit  = cur;
        row.typed_result.local_best_bit = best;
        row.typed_result.velocity     = VEL_W'(vel);
        return row;
    endfunction

    function automatic stim_row_t gain_row(input logic sel, input logic [GAIN_W-1:0] value);
        stim_row_t row;
        row           = item_row(CMD_UNUSED, 0, 1'b0, '0, 1'b0, 1'b0, 1'b0, 0);
        row.cfg_write = 1'b1;
        row.cfg_sel   = sel;
        row.cfg_value = value;
        return row;
    endfunction

    // offer one item, wait for its acceptance, record what should come back
    task automatic send_item(input in_item_t it, input bit typed_in, input out_item_t typed_result);
        out_item_t predicted;
        if (idle_bursts && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        predicted = predict_element(it);
        pending_results.push_back(typed_in ? typed_result : predicted);
        items_sent++;
    endtask

    // drop valid and wait until every result has come back
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_gain(input logic sel, input logic [GAIN_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= sel;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        if (sel == CFG_ALPHA) begin
            alpha_gain_q = value;
        end else begin
            beta_gain_q = value;
        end
    endtask

    task automatic check_field(input string name, input logic signed [31:0] want,
                               input logic signed [31:0] got);
        if (got !== want) begin
            errors++;
            if (errors <= MAX_SHOWN) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
        end
    endtask

    // result side: random stalls on m_ready
    initial begin
        m_ready <= 1'b1;
        forever begin
            @(posedge aclk);
            if (idle_bursts && m_ready && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge aclk);
                m_ready <= 1'b1;
            end
        end
    end

    // compare each accepted result with the oldest expectation
    always @(posedge aclk) begin : result_check
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= MAX_SHOWN) begin
                    $display("%0t: result with none expected, expected none, actual %p",
                             $time, m_data);
                end
            end else begin
                want = pending_results.pop_front();
                check_field("out_index", 32'(want.out_index), 32'(m_data.out_index));
                check_field("current_bit", 32'(want.current_bit), 32'(m_data.current_bit));
                check_field("local_best_bit", 32'(want.local_best_bit),
                            32'(m_data.local_best_bit));
                check_field("velocity", 32'(want.velocity), 32'(m_data.velocity));
                results_checked++;
            end
        end
    end

    // stimulus
    initial begin
        stim_row_t row;
        in_item_t it;
        out_item_t no_result;
        logic [GAIN_W-1:0] a_val;
        logic [GAIN_W-1:0] b_val;
        int hot_base;
        int pick;
        int k;
        int phase;

        aresetn     <= 1'b0;
        s_valid     <= 1'b0;
        s_data      <= '0;
        cfg_wr_en   <= 1'b0;
        cfg_index   <= CFG_ALPHA;
        cfg_wr_data <= '0;
        idle_bursts = 1'b1;
        no_result   = '0;
        errors = 0;
        items_sent = 0;
        results_checked = 0;
        for (k = 0; k < ELEMENTS; k++) begin
            pos_bits[k]   = 1'b0;
            best_bits[k]  = 1'b0;
            velocities[k] = '0;
        end
        alpha_gain_q = GAIN_RESET;
        beta_gain_q  = GAIN_RESET;

        // reset gains: unused commands, init and save at the top index, two updates, one neutral
        directed_rows.push_back(item_row(CMD_UNUSED, 0, 1'b1, 16'hFFFF, 1, 1'b0, 1'b0, 0));
        directed_rows.push_back(item_row(CMD_INIT, 63, 1'b0, 16'h0001, 1, 1'b1, 1'b0, 0));
        directed_rows.push_back(item_row(CMD_SAVE, 63, 1'b0, 16'h0000, 1, 1'b1, 1'b1, 0));
        directed_rows.push_back(item_row(CMD_UNUSED, 63, 1'b0, 16'h1234, 1, 1'b1, 1'b1, 0));
        directed_rows.push_back(item_row(CMD_UPDATE, 5, 1'b0, 16'hFFFF, 1, 1'b0, 1'b0, 0));
        directed_rows.push_back(item_row(CMD_UPDATE, 5, 1'b1, 16'h0000, 0, 1'b0, 1'b0, 0));
        // full gains: drive one element to positive saturation
        directed_rows.push_back(gain_row(CFG_ALPHA, GAIN_MAX));
        directed_rows.push_back(gain_row(CFG_BETA, GAIN_MAX));
        directed_rows.push_back(item_row(CMD_INIT, 1, 1'b0, 16'h0001, 1, 1'b1, 1'b0, 0));
        directed_rows.push_back(item_row(CMD_SAVE, 1, 1'b0, 16'h0000, 1, 1'b1, 1'b1, 0));
        directed_rows.push_back(item_row(CMD_INIT, 1, 1'b0, 16'hFFFE, 1, 1'b0, 1'b1, 0));
        for (k = 1; k <= 5; k++) begin
            directed_rows.push_back(item_row(CMD_UPDATE, 1, 1'b1, 16'hFFFF, 1, 1'b0, 1'b1,
                                             (8190 * k > 32767) ? 32767 : 8190 * k));
        end
        // and another to negative saturation
        directed_rows.push_back(item_row(CMD_INIT, 2, 1'b0, 16'h8001, 1, 1'b1, 1'b0, 0));
        for (k = 1; k <= 5; k++) begin
            directed_rows.push_back(item_row(CMD_UPDATE, 2, 1'b0, 16'h0000, 1, 1'b1, 1'b0,
                                             (-8190 * k < -32768) ? -32768 : -8190 * k));
        end
        // zero gains: velocity holds, draws at both table ends and the top boundary
        directed_rows.push_back(gain_row(CFG_ALPHA, '0));
        directed_rows.push_back(gain_row(CFG_BETA, '0));
        directed_rows.push_back(item_row(CMD_UPDATE, 2, 1'b1, 16'h0000, 1, 1'b1, 1'b0, -32768));
        directed_rows.push_back(item_row(CMD_UPDATE, 1, 1'b0, 16'd65507, 1, 1'b1, 1'b1, 32767));
        directed_rows.push_back(item_row(CMD_UPDATE, 1, 1'b0, 16'd65508, 1, 1'b0, 1'b1, 32767));

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table
        foreach (directed_rows[n]) begin
            row = directed_rows[n];
            if (row.cfg_write) begin
                wait_idle();
                write_gain(row.cfg_sel, row.cfg_value);
            end else begin
                send_item(row.item, row.typed_in, row.typed_result);
            end
        end
        directed_items = items_sent;

        // random phases, each under its own pair of gains
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            idle_bursts = (phase != 3) && (phase != RANDOM_PHASES - 1);
            case (phase)
                0: begin
                    a_val = GAIN_MAX;
                    b_val = GAIN_MAX;
                end
                1: begin
                    a_val = '0;
                    b_val = GAIN_MAX;
                end
                2: begin
                    a_val = GAIN_MAX;
                    b_val = '0;
                end
                default: begin
                    a_val = GAIN_W'($urandom_range(0, 4095));
                    b_val = GAIN_W'($urandom_range(0, 4095));
                end
            endcase
            wait_idle();
            write_gain(CFG_ALPHA, a_val);
            write_gain(CFG_BETA, b_val);
            // half the items hit a few hot elements so state builds up
            hot_base = $urandom_range(0, ELEMENTS - 4);
            repeat (PHASE_ITEMS) begin
                pick = $urandom_range(0, 19);
                it.command = (pick < 4) ? CMD_INIT : (pick < 14) ? CMD_UPDATE :
                             (pick < 18) ? CMD_SAVE : CMD_UNUSED;
                it.element_index = IDX_W'($urandom_range(0, 1) ?
                                   hot_base + $urandom_range(0, 3) : $urandom_range(0, 63));
                it.global_best_bit = 1'($urandom_range(0, 1));
                if ($urandom_range(0, 15) == 0) begin
                    it.random_value = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                end else begin
                    it.random_value = RND_W'($urandom_range(0, 65535));
                end
                send_item(it, 1'b0, no_result);
            end
        end

        // drain
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("ran %0d items (%0d directed) over %0d gain settings plus reset gains",
                 items_sent, directed_items, RANDOM_PHASES + 2);
        $display("checked %0d results, %0d field errors", results_checked, errors);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

FILE: binary_swarm_particle_update.f
sv/bspu_pkg.sv
sv/bspu_ram.sv
sv/binary_swarm_particle_update.sv
tb/binary_swarm_particle_update_test.sv
